### rtl/alba_pkg.sv
// ============================================================================
// alba_pkg: shared types, constants and tables for the audio level band tracker
// Holds field widths, band limits, the half-dB coefficient table and the
// queue entry type passed between the front and back parts.
// ============================================================================
package alba_pkg;

    // Field widths
    localparam int LevelW = 16;
    localparam int BaseW  = 15;
    localparam int BandW  = 5;
    localparam int CoefW  = 13;
    localparam int ThrW   = 16;
    localparam int ProdW  = BaseW + CoefW;
    localparam int CoefShift = 12;

    // Band limits
    localparam int BandCount   = 25;
    localparam int ThrCount    = BandCount - 1;
    localparam int ThrIdxW     = $clog2(ThrCount);
    localparam int BandMid     = 12;
    localparam int BandMax     = 24;
    localparam int BandLowEdge = 2;
    localparam int BandTopEdge = 22;

    // Reset value of the base level register
    localparam int BaseReset = 4096;

    // Queue between front and back (power of two)
    localparam int QDepth = 2;
    localparam int QPtrW  = $clog2(QDepth);
    localparam int QCntW  = $clog2(QDepth + 1);

    typedef logic [LevelW-1:0] level_t;
    typedef logic [BaseW-1:0]  base_t;
    typedef logic [BandW-1:0]  band_t;
    typedef logic [CoefW-1:0]  coef_t;
    typedef logic [ThrW-1:0]   thr_t;
    typedef logic [ProdW-1:0]  prod_t;

    // Head of the raw band queue as seen by the back part
    typedef struct packed {
        logic  valid;
        band_t band;
    } q_head_t;

    // Half-dB coefficients, 4096 is unity
    function automatic coef_t coef_of(input band_t k);
        coef_t c;
        begin
            case (k)
                5'd0:    c = 13'd2053;
                5'd1:    c = 13'd2175;
                5'd2:    c = 13'd2303;
                5'd3:    c = 13'd2440;
                5'd4:    c = 13'd2584;
                5'd5:    c = 13'd2738;
                5'd6:    c = 13'd2900;
                5'd7:    c = 13'd3072;
                5'd8:    c = 13'd3254;
                5'd9:    c = 13'd3446;
                5'd10:   c = 13'd3651;
                5'd11:   c = 13'd3867;
                5'd12:   c = 13'd4096;
                5'd13:   c = 13'd4339;
                5'd14:   c = 13'd4596;
                5'd15:   c = 13'd4868;
                5'd16:   c = 13'd5157;
                5'd17:   c = 13'd5462;
                5'd18:   c = 13'd5786;
                5'd19:   c = 13'd6129;
                5'd20:   c = 13'd6492;
                5'd21:   c = 13'd6876;
                5'd22:   c = 13'd7284;
                5'd23:   c = 13'd7715;
                5'd24:   c = 13'd8173;
                default: c = '0;
            endcase
            return c;
        end
    endfunction

endpackage

### rtl/audio_level_band_tracker_top.sv
// ============================================================================
// audio_level_band_tracker_top: audio level to hysteresis band tracker
// Classifies each audio level against 24 scaled band thresholds and tracks
// a held band index with edge-aware hysteresis.
// ============================================================================
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------
//  config   | cfg_valid/cfg_ready  | ref_level   [14:0]
//  input    | in_valid/in_ready    | mean_level  [15:0]
//  output   | out_valid/out_ready  | band_index  [4:0]
//
//  One level per cycle sustained while no rebuild runs and the queue has
//  room; the queue registers the raw band at the transfer and the output
//  register loads it when the back part pops it from the queue.
//  A base level write rebuilds the thresholds with one shared multiplier,
//  one band a cycle; input and config are not ready while it runs.
//  After reset the thresholds match base 4096 and the held band is 12.
//  An output stall fills the two-entry queue before input ready drops.
//
module audio_level_band_tracker_top
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  alba_pkg::base_t     ref_level,
    input  logic                in_valid,
    output logic                in_ready,
    input  alba_pkg::level_t    mean_level,
    output logic                out_valid,
    input  logic                out_ready,
    output alba_pkg::band_t     band_index
);

    logic                q_ready;
    logic                q_push;
    alba_pkg::band_t     q_band;
    logic                q_pop;
    alba_pkg::q_head_t   q_head;

    alba_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .ref_level   (ref_level),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .mean_level  (mean_level),
        .q_ready     (q_ready),
        .q_push      (q_push),
        .q_band      (q_band)
    );

    alba_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_band  (q_band),
        .push_ready (q_ready),
        .pop        (q_pop),
        .head       (q_head)
    );

    alba_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (q_head),
        .pop        (q_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .band_index (band_index)
    );

`ifndef NO_ASSERTIONS
    // A config transfer starts a threshold rebuild
    a_cfg_starts_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_valid && cfg_ready) |=> !cfg_ready)
        else $error("config transfer did not start a threshold rebuild");

    // No level is taken while thresholds are being rebuilt
    a_no_input_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        !cfg_ready |-> !in_ready)
        else $error("input ready during threshold rebuild");

    // Results stay within the band range
    a_band_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (band_index <= alba_pkg::band_t'(alba_pkg::BandMax)))
        else $error("band index out of range");

    // A queued raw band reaches the back part whenever the output is free
    a_queue_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (q_head.valid && !out_valid) |-> q_pop)
        else $error("queued band not taken with output free");
`endif

endmodule

### rtl/alba_front.sv
// ============================================================================
// alba_front: base level register, threshold table and level classifier
// Keeps one threshold per band, swept one band a cycle when the base level is
// written, and turns each accepted level into a raw band for the queue.
// ============================================================================
module alba_front
(
    input  logic                clk,
    input  logic                rst_n,
    // configuration write
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  alba_pkg::base_t     ref_level,
    // level input
    input  logic                in_valid,
    output logic                in_ready,
    input  alba_pkg::level_t    mean_level,
    // queue push side
    input  logic                q_ready,
    output logic                q_push,
    output alba_pkg::band_t     q_band
);

    alba_pkg::base_t                  base_reg;
    alba_pkg::thr_t                   thr_reg [alba_pkg::ThrCount];
    logic                             sweep_busy_reg;
    logic                             sweep_busy_next;
    logic [alba_pkg::ThrIdxW-1:0]     sweep_idx_reg;
    logic [alba_pkg::ThrIdxW-1:0]     sweep_idx_next;
    logic                             cfg_xfer;
    alba_pkg::prod_t                  prod;
    alba_pkg::thr_t                   thr_new;
    alba_pkg::band_t                  raw_band;

    assign cfg_ready = !sweep_busy_reg;
    assign cfg_xfer  = cfg_valid && cfg_ready;
    assign in_ready  = !sweep_busy_reg && q_ready;
    assign q_push    = in_valid && in_ready;
    assign q_band    = raw_band;

    // Scale the base level by the coefficient of the band being rebuilt
    assign prod = alba_pkg::prod_t'(base_reg)
                * alba_pkg::prod_t'(alba_pkg::coef_of(
                      alba_pkg::band_t'(sweep_idx_reg) + alba_pkg::band_t'(1)));
    assign thr_new = prod[alba_pkg::ProdW-1:alba_pkg::CoefShift];

    // Advance the rebuild sweep; start it on a configuration transfer
    always_comb
    begin
        sweep_busy_next = sweep_busy_reg;
        sweep_idx_next  = sweep_idx_reg;
        if (cfg_xfer)
        begin
            sweep_busy_next = 1'b1;
            sweep_idx_next  = '0;
        end
        else if (sweep_busy_reg)
        begin
            if (sweep_idx_reg == alba_pkg::ThrIdxW'(alba_pkg::ThrCount - 1))
            begin
                sweep_busy_next = 1'b0;
            end
            else
            begin
                sweep_idx_next = sweep_idx_reg + alba_pkg::ThrIdxW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_busy_reg <= 1'b0;
            sweep_idx_reg  <= '0;
        end
        else
        begin
            sweep_busy_reg <= sweep_busy_next;
            sweep_idx_reg  <= sweep_idx_next;
        end
    end

    // Hold the base level and the thresholds; reset values match base 4096
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= alba_pkg::base_t'(alba_pkg::BaseReset);
            for (int i = 0; i < alba_pkg::ThrCount; i++)
            begin
                thr_reg[i] <= alba_pkg::thr_t'(alba_pkg::coef_of(alba_pkg::band_t'(i + 1)));
            end
        end
        else
        begin
            if (cfg_xfer)
            begin
                base_reg <= ref_level;
            end
            if (sweep_busy_reg)
            begin
                thr_reg[sweep_idx_reg] <= thr_new;
            end
        end
    end

    // Pick the highest band whose threshold is at or below the level
    always_comb
    begin
        raw_band = '0;
        for (int k = 1; k <= alba_pkg::ThrCount; k++)
        begin
            if (thr_reg[k-1] <= mean_level)
            begin
                raw_band = alba_pkg::band_t'(k);
            end
        end
    end

endmodule

### rtl/alba_queue.sv
// ============================================================================
// alba_queue: short raw band queue between front and back
// Lets the classifier keep taking levels while the back part is stalled.
// ============================================================================
module alba_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  alba_pkg::band_t     push_band,
    output logic                push_ready,
    input  logic                pop,
    output alba_pkg::q_head_t   head
);

    alba_pkg::band_t               mem_reg [alba_pkg::QDepth];
    logic [alba_pkg::QPtrW-1:0]    wr_ptr_reg;
    logic [alba_pkg::QPtrW-1:0]    rd_ptr_reg;
    logic [alba_pkg::QCntW-1:0]    count_reg;
    logic [alba_pkg::QCntW-1:0]    count_next;
    logic                          do_push;
    logic                          do_pop;

    assign push_ready = (count_reg != alba_pkg::QCntW'(alba_pkg::QDepth));
    assign do_push    = push && push_ready;
    assign do_pop     = pop && head.valid;
    assign head.valid = (count_reg != '0);
    assign head.band  = mem_reg[rd_ptr_reg];

    // Track fill level
    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + alba_pkg::QCntW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - alba_pkg::QCntW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + alba_pkg::QPtrW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + alba_pkg::QPtrW'(1);
            end
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_band;
        end
    end

endmodule

### rtl/alba_back.sv
// ============================================================================
// alba_back: hysteresis update and output register
// Pops raw bands, moves the held band by the hysteresis rule and presents
// the result from an output register.
// ============================================================================
module alba_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  alba_pkg::q_head_t   head,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output alba_pkg::band_t     band_index
);

    alba_pkg::band_t   held_reg;
    alba_pkg::band_t   held_next;
    alba_pkg::band_t   out_band_reg;
    logic              out_valid_reg;
    alba_pkg::band_t   raw;
    alba_pkg::band_t   diff;

    assign raw        = head.band;
    assign pop        = head.valid && (!out_valid_reg || out_ready);
    assign out_valid  = out_valid_reg;
    assign band_index = out_band_reg;

    // Step toward the raw band when far; jump only at the edges
    always_comb
    begin
        diff      = (held_reg > raw) ? (held_reg - raw) : (raw - held_reg);
        held_next = held_reg;
        if (diff > alba_pkg::band_t'(1))
        begin
            held_next = (held_reg < raw) ? (held_reg + alba_pkg::band_t'(1))
                                         : (held_reg - alba_pkg::band_t'(1));
        end
        else if ((held_reg < alba_pkg::band_t'(alba_pkg::BandLowEdge) && raw < held_reg) ||
                 (held_reg > alba_pkg::band_t'(alba_pkg::BandTopEdge) && raw > held_reg))
        begin
            held_next = raw;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg      <= alba_pkg::band_t'(alba_pkg::BandMid);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                held_reg      <= held_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Load the result on each pop
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_band_reg <= held_next;
        end
    end

endmodule
